// ===== rtl/core/tpmc_pkg.sv =====
// Shared types and constants for the triangle pair merge check.
// Holds controller/datapath command and status structs; no dependencies.
package tpmc_pkg;

  localparam int COORD_BITS = 20;
  localparam int EPS_W      = 16;
  localparam int DIG_W      = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  typedef enum logic [2:0] {
    MS_DSQ,
    MS_EE,
    MS_RHS,
    MS_P,
    MS_Q,
    MS_SQ
  } msel_e;

  typedef struct packed {
    logic        store_s;
    logic        load_n;
    logic        match;
    logic        setup;
    logic        mul_start;
    logic        wset;
    logic        decide;
    logic        load_out;
    logic        ok;
    logic [1:0]  i;
    logic [1:0]  j;
    logic [1:0]  k;
    msel_e       msel;
  } cmd_t;

  typedef struct packed {
    logic        u0_ok;
    logic        u1_ok;
    logic [2:0]  shared;
    logic        mul_done;
    logic        ext_found;
    logic        inl;
    logic        out_free;
  } sts_t;

endpackage

// ===== rtl/core/tpmc_mul.sv =====
// Iterative unsigned multiplier, one DigW-bit digit of b per cycle.
// Standalone; used by tpmc_datapath.
module tpmc_mul #(
  parameter int OpW  = 48,
  parameter int DigW = tpmc_pkg::DIG_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [OpW-1:0]     a_i,
  input  logic [OpW-1:0]     b_i,
  output logic               done_o,
  output logic [2*OpW-1:0]   prod_o
);

  localparam int Steps = OpW / DigW;
  localparam int CntW  = $clog2(Steps + 1);

  logic [OpW-1:0]      a_q;
  logic [2*OpW-1:0]    acc_q;
  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [OpW+DigW-1:0] pp;
  logic [OpW+DigW:0]   sum;
  logic [2*OpW:0]      nxt;

  always_comb begin
    pp  = a_q * acc_q[DigW-1:0];
    sum = (OpW+DigW+1)'(acc_q[2*OpW-1:OpW]) + (OpW+DigW+1)'(pp);
    nxt = {sum, acc_q[OpW-1:DigW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {{OpW{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= nxt[2*OpW-1:0];
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/core/tpmc_datapath.sv =====
// Datapath: triangle storage, vertex match matrix, line test accumulators, result register.
// Depends on tpmc_pkg and tpmc_mul.
module tpmc_datapath #(
  parameter int CoordBits = tpmc_pkg::COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tpmc_pkg::cmd_t                      cmd_i,
  output tpmc_pkg::sts_t                      sts_o,
  input  logic                                cfg_we_i,
  input  logic [tpmc_pkg::EPS_W-1:0]          cfg_wdata_i,
  input  logic [2:0][2:0][CoordBits-1:0]      in_tri_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                merged_o,
  output logic [2:0][2:0][CoordBits-1:0]      out_tri_o
);

  localparam int C    = CoordBits;
  localparam int DW   = C + 1;
  localparam int EW   = tpmc_pkg::EPS_W;
  localparam int CMPW = (DW > EW) ? DW : EW;
  localparam int PW   = 2 * C + 4;
  localparam int MRAW = (PW > 2 * EW) ? PW : 2 * EW;
  localparam int DG   = tpmc_pkg::DIG_W;
  localparam int MW   = ((MRAW + DG - 1) / DG) * DG;
  localparam int LW   = 2 * MW + 2;

  typedef logic [2:0][C-1:0] vtx_t;

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  vtx_t s_q [3];
  vtx_t n_q [3];
  vtx_t o_q, e_q, x_q;
  logic signed [DW-1:0] d_q [3];
  logic signed [DW-1:0] w_q [3];
  logic [2:0][2:0] mt_q;
  logic [EW-1:0] eps_q;
  logic [MW-1:0] dl_q, ee_q, c_q;
  logic [LW-1:0] rhs_q, lhs_q;
  logic signed [PW-1:0] p_q;
  tpmc_pkg::msel_e msel_q;
  logic sg_q, ext_q, inl_q;
  logic out_valid_q, merged_q;
  vtx_t m0_q, m1_q, m2_q;

  logic [2:0] row_hit, col_hit;
  logic [1:0] u0, u1, sidx, nidx, k1, k2;
  vtx_t vs, vn;
  logic close;
  logic signed [DW-1:0] df;
  logic [CMPW-1:0] mg;
  logic [MW-1:0] op_a, op_b;
  logic sg;
  logic mul_done;
  logic [2*MW-1:0] prod;
  logic signed [PW-1:0] pv, spv, cv;
  logic on_line;
  logic out_free;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_hit[r] = |mt_q[r];
      col_hit[r] = mt_q[0][r] | mt_q[1][r] | mt_q[2][r];
    end
    u0 = !row_hit[0] ? 2'd0 : (!row_hit[1] ? 2'd1 : 2'd2);
    u1 = !col_hit[0] ? 2'd0 : (!col_hit[1] ? 2'd1 : 2'd2);
    sidx = cmd_i.setup ? u0 : cmd_i.i;
    nidx = cmd_i.setup ? u1 : cmd_i.j;
    vs = s_q[sidx];
    vn = n_q[nidx];
    close = 1'b1;
    for (int a = 0; a < 3; a++) begin
      df = DW'($signed(vs[a])) - DW'($signed(vn[a]));
      mg = CMPW'(mag_d(df));
      if (mg > CMPW'(eps_q)) close = 1'b0;
    end
  end

  always_comb begin
    k1 = (cmd_i.k == 2'd2) ? 2'd0 : cmd_i.k + 2'd1;
    k2 = (cmd_i.k == 2'd0) ? 2'd2 : cmd_i.k - 2'd1;
    op_a = '0;
    op_b = '0;
    sg   = 1'b0;
    case (cmd_i.msel)
      tpmc_pkg::MS_DSQ: begin
        op_a = MW'(mag_d(d_q[cmd_i.k]));
        op_b = op_a;
      end
      tpmc_pkg::MS_EE: begin
        op_a = MW'(eps_q);
        op_b = op_a;
      end
      tpmc_pkg::MS_RHS: begin
        op_a = ee_q;
        op_b = dl_q;
      end
      tpmc_pkg::MS_P: begin
        op_a = MW'(mag_d(w_q[k1]));
        op_b = MW'(mag_d(d_q[k2]));
        sg   = w_q[k1][DW-1] ^ d_q[k2][DW-1];
      end
      tpmc_pkg::MS_Q: begin
        op_a = MW'(mag_d(w_q[k2]));
        op_b = MW'(mag_d(d_q[k1]));
        sg   = w_q[k2][DW-1] ^ d_q[k1][DW-1];
      end
      tpmc_pkg::MS_SQ: begin
        op_a = c_q;
        op_b = c_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  tpmc_mul #(.OpW(MW), .DigW(DG)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  always_comb begin
    pv      = $signed(PW'(prod));
    spv     = sg_q ? -pv : pv;
    cv      = p_q - spv;
    on_line = lhs_q <= rhs_q;
    out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q       <= tpmc_pkg::EPS_RESET;
      ext_q       <= 1'b0;
      inl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) eps_q <= cfg_wdata_i;
      if (cmd_i.setup) begin
        ext_q <= 1'b0;
        inl_q <= 1'b0;
      end else if (cmd_i.decide) begin
        if (!on_line) ext_q <= 1'b1;
        if (on_line) inl_q <= 1'b1;
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_s) begin
      for (int v = 0; v < 3; v++) s_q[v] <= in_tri_i[v];
    end
    if (cmd_i.load_n) begin
      for (int v = 0; v < 3; v++) n_q[v] <= in_tri_i[v];
    end
    if (cmd_i.match) mt_q[cmd_i.i][cmd_i.j] <= close;
    if (cmd_i.setup) begin
      o_q  <= vs;
      e_q  <= vn;
      dl_q <= '0;
      for (int a = 0; a < 3; a++) begin
        d_q[a] <= DW'($signed(vn[a])) - DW'($signed(vs[a]));
      end
    end
    if (cmd_i.wset) begin
      lhs_q <= '0;
      for (int a = 0; a < 3; a++) begin
        w_q[a] <= DW'($signed(vs[a])) - DW'($signed(o_q[a]));
      end
    end
    if (cmd_i.decide && !on_line && !ext_q) x_q <= vs;
    if (cmd_i.mul_start) begin
      msel_q <= cmd_i.msel;
      sg_q   <= sg;
    end
    if (mul_done) begin
      case (msel_q)
        tpmc_pkg::MS_DSQ: dl_q  <= dl_q + prod[MW-1:0];
        tpmc_pkg::MS_EE:  ee_q  <= prod[MW-1:0];
        tpmc_pkg::MS_RHS: rhs_q <= LW'(prod);
        tpmc_pkg::MS_P:   p_q   <= spv;
        tpmc_pkg::MS_Q:   c_q   <= MW'(cv[PW-1] ? -cv : cv);
        tpmc_pkg::MS_SQ:  lhs_q <= lhs_q + LW'(prod);
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      merged_q <= cmd_i.ok;
      m0_q     <= cmd_i.ok ? o_q : '0;
      m1_q     <= cmd_i.ok ? e_q : '0;
      m2_q     <= cmd_i.ok ? x_q : '0;
    end
  end

  always_comb begin
    sts_o.u0_ok     = ~&row_hit;
    sts_o.u1_ok     = ~&col_hit;
    sts_o.shared    = row_hit;
    sts_o.mul_done  = mul_done;
    sts_o.ext_found = ext_q;
    sts_o.inl       = inl_q;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign merged_o     = merged_q;
  assign out_tri_o[0] = m0_q;
  assign out_tri_o[1] = m1_q;
  assign out_tri_o[2] = m2_q;

endmodule

// ===== rtl/core/tpmc_ctrl.sv =====
// Controller: sequences storing, vertex matching, line tests and result hand-off.
// Depends on tpmc_pkg; drives tpmc_datapath through cmd_t and reads sts_t.
module tpmc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           first_of_pair_i,
  output tpmc_pkg::cmd_t cmd_o,
  input  tpmc_pkg::sts_t sts_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_MSTART = 3'd3;
  localparam logic [2:0] S_MWAIT  = 3'd4;
  localparam logic [2:0] S_WSET   = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_q, state_d;
  logic have_first_q, have_first_d, fail_q, fail_d, phase_q, phase_d;
  logic [1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [2:0] sub_q, sub_d;
  logic in_acc;

  always_comb begin
    state_d      = state_q;
    have_first_d = have_first_q;
    fail_d       = fail_q;
    phase_d      = phase_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    sub_d        = sub_q;
    cmd_o        = '0;
    cmd_o.i      = i_q;
    cmd_o.j      = j_q;
    cmd_o.k      = phase_q ? k_q : sub_q[1:0];
    if (!phase_q) begin
      cmd_o.msel = (sub_q == 3'd3) ? tpmc_pkg::MS_EE :
                   (sub_q == 3'd4) ? tpmc_pkg::MS_RHS : tpmc_pkg::MS_DSQ;
    end else begin
      cmd_o.msel = (sub_q == 3'd0) ? tpmc_pkg::MS_P :
                   (sub_q == 3'd1) ? tpmc_pkg::MS_Q : tpmc_pkg::MS_SQ;
    end
    in_stall_o = (state_q != S_IDLE);
    in_acc     = in_valid_i && !in_stall_o;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (first_of_pair_i) begin
            cmd_o.store_s = 1'b1;
            have_first_d  = 1'b1;
          end else begin
            cmd_o.load_n = 1'b1;
            if (have_first_q) begin
              have_first_d = 1'b0;
              i_d          = 2'd0;
              j_d          = 2'd0;
              state_d      = S_MATCH;
            end else begin
              fail_d  = 1'b1;
              state_d = S_OUT;
            end
          end
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        if (j_q == 2'd2) begin
          j_d = 2'd0;
          if (i_q == 2'd2) state_d = S_SETUP;
          else i_d = i_q + 2'd1;
        end else begin
          j_d = j_q + 2'd1;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        if (!(sts_i.u0_ok && sts_i.u1_ok)) begin
          fail_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          fail_d  = 1'b0;
          phase_d = 1'b0;
          sub_d   = 3'd0;
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts_i.mul_done) begin
          if (!phase_q) begin
            if (sub_q == 3'd4) begin
              phase_d = 1'b1;
              i_d     = 2'd0;
              state_d = S_WSET;
            end else begin
              sub_d   = sub_q + 3'd1;
              state_d = S_MSTART;
            end
          end else if (sub_q == 3'd2) begin
            sub_d = 3'd0;
            if (k_q == 2'd2) begin
              state_d = S_DECIDE;
            end else begin
              k_d     = k_q + 2'd1;
              state_d = S_MSTART;
            end
          end else begin
            sub_d   = sub_q + 3'd1;
            state_d = S_MSTART;
          end
        end
      end
      S_WSET: begin
        if (sts_i.shared[i_q]) begin
          cmd_o.wset = 1'b1;
          k_d        = 2'd0;
          sub_d      = 3'd0;
          state_d    = S_MSTART;
        end else if (i_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          i_d = i_q + 2'd1;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (i_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          i_d     = i_q + 2'd1;
          state_d = S_WSET;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.ok       = !fail_q && sts_i.ext_found && sts_i.inl;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      have_first_q <= 1'b0;
      fail_q       <= 1'b0;
      phase_q      <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      sub_q        <= '0;
    end else begin
      state_q      <= state_d;
      have_first_q <= have_first_d;
      fail_q       <= fail_d;
      phase_q      <= phase_d;
      i_q          <= i_d;
      j_q          <= j_d;
      k_q          <= k_d;
      sub_q        <= sub_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result loaded while output register busy");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> state_q == S_MWAIT)
    else $error("multiplier done outside wait state");

  a_consume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !first_of_pair_i) |=> !have_first_q)
    else $error("stored triangle not consumed by compare");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == S_IDLE)
    else $error("controller did not return to idle after result");

endmodule

// ===== rtl/core/triangle_pair_merge_check.sv =====
// Triangle pair merge check, top level. A store transaction captures the triangle.
// A compare matches every stored vertex against every new vertex, sets up the line from
// the first unshared vertices, forms |d|^2 and eps^2*|d|^2 on the shared iterative
// multiplier, runs the line test for each shared stored vertex, then loads the result.
// One transaction at a time: the input stalls whenever the controller is not idle.
// Reset is asynchronous active low: no stored triangle, epsilon = 1, no result.
module triangle_pair_merge_check #(
  parameter int CoordBits = tpmc_pkg::COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpmc_pkg::EPS_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              first_of_pair_i,
  input  logic signed [CoordBits-1:0]       ax_i,
  input  logic signed [CoordBits-1:0]       ay_i,
  input  logic signed [CoordBits-1:0]       az_i,
  input  logic signed [CoordBits-1:0]       bx_i,
  input  logic signed [CoordBits-1:0]       by_i,
  input  logic signed [CoordBits-1:0]       bz_i,
  input  logic signed [CoordBits-1:0]       cx_i,
  input  logic signed [CoordBits-1:0]       cy_i,
  input  logic signed [CoordBits-1:0]       cz_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              merged_o,
  output logic signed [CoordBits-1:0]       m0x_o,
  output logic signed [CoordBits-1:0]       m0y_o,
  output logic signed [CoordBits-1:0]       m0z_o,
  output logic signed [CoordBits-1:0]       m1x_o,
  output logic signed [CoordBits-1:0]       m1y_o,
  output logic signed [CoordBits-1:0]       m1z_o,
  output logic signed [CoordBits-1:0]       m2x_o,
  output logic signed [CoordBits-1:0]       m2y_o,
  output logic signed [CoordBits-1:0]       m2z_o
);

  tpmc_pkg::cmd_t cmd;
  tpmc_pkg::sts_t sts;
  logic [2:0][2:0][CoordBits-1:0] in_tri, out_tri;

  assign in_tri[0][0] = ax_i;
  assign in_tri[0][1] = ay_i;
  assign in_tri[0][2] = az_i;
  assign in_tri[1][0] = bx_i;
  assign in_tri[1][1] = by_i;
  assign in_tri[1][2] = bz_i;
  assign in_tri[2][0] = cx_i;
  assign in_tri[2][1] = cy_i;
  assign in_tri[2][2] = cz_i;

  tpmc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .first_of_pair_i (first_of_pair_i),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  tpmc_datapath #(.CoordBits(CoordBits)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tri_i    (in_tri),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .merged_o    (merged_o),
    .out_tri_o   (out_tri)
  );

  assign m0x_o = out_tri[0][0];
  assign m0y_o = out_tri[0][1];
  assign m0z_o = out_tri[0][2];
  assign m1x_o = out_tri[1][0];
  assign m1y_o = out_tri[1][1];
  assign m1z_o = out_tri[1][2];
  assign m2x_o = out_tri[2][0];
  assign m2y_o = out_tri[2][1];
  assign m2z_o = out_tri[2][2];

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for triangle_pair_merge_check: stores and compares random and
// constructed triangle pairs and checks every result against an in-bench predictor.
// Depends on tpmc_pkg and the triangle_pair_merge_check RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = tpmc_pkg::COORD_BITS;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;

  typedef logic signed [2:0][CW-1:0] vert_t;
  typedef struct packed {
    logic              first;
    logic [8:0][CW-1:0] c;
  } tri_t;
  typedef struct packed {
    logic              merged;
    logic [8:0][CW-1:0] m;
  } merge_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [tpmc_pkg::EPS_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  tri_t item_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic merged;
  logic signed [CW-1:0] mo [9];

  tri_t feed_q[$];
  merge_t merge_expected_q[$];
  logic [8:0][CW-1:0] stored_tri;
  bit have_first = 1'b0;
  longint eps_now = 1;
  int fails = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  triangle_pair_merge_check dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .first_of_pair_i(item_q.first),
    .ax_i(item_q.c[0]), .ay_i(item_q.c[1]), .az_i(item_q.c[2]),
    .bx_i(item_q.c[3]), .by_i(item_q.c[4]), .bz_i(item_q.c[5]),
    .cx_i(item_q.c[6]), .cy_i(item_q.c[7]), .cz_i(item_q.c[8]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .merged_o(merged),
    .m0x_o(mo[0]), .m0y_o(mo[1]), .m0z_o(mo[2]),
    .m1x_o(mo[3]), .m1y_o(mo[4]), .m1z_o(mo[5]),
    .m2x_o(mo[6]), .m2y_o(mo[7]), .m2z_o(mo[8])
  );

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit close_v(longint p[3], longint q[3]);
    for (int k = 0; k < 3; k++) begin
      if (mag(p[k] - q[k]) > eps_now) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit shared_v(longint p[3], longint u[3][3]);
    for (int j = 0; j < 3; j++) begin
      if (close_v(p, u[j])) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int first_unshared(longint t[3][3], longint u[3][3]);
    for (int i = 0; i < 3; i++) begin
      if (!shared_v(t[i], u)) return i;
    end
    return -1;
  endfunction

  function automatic bit on_line(longint p[3], longint o[3], longint e[3]);
    longint w[3];
    longint d[3];
    longint cr[3];
    logic [127:0] a;
    logic [127:0] lhs;
    logic [127:0] dl;
    logic [127:0] rhs;
    lhs = '0;
    dl = '0;
    for (int k = 0; k < 3; k++) begin
      w[k] = p[k] - o[k];
      d[k] = e[k] - o[k];
    end
    cr[0] = w[1] * d[2] - w[2] * d[1];
    cr[1] = w[2] * d[0] - w[0] * d[2];
    cr[2] = w[0] * d[1] - w[1] * d[0];
    for (int k = 0; k < 3; k++) begin
      a = 128'(mag(cr[k]));
      lhs = lhs + a * a;
      a = 128'(mag(d[k]));
      dl = dl + a * a;
    end
    rhs = 128'(eps_now) * 128'(eps_now) * dl;
    return lhs <= rhs;
  endfunction

  function automatic void predict_merge(tri_t it);
    longint s[3][3];
    longint n[3][3];
    merge_t r;
    int u0;
    int u1;
    int ext;
    bit inl;
    bit on;
    r = '0;
    ext = -1;
    inl = 1'b0;
    if (it.first) begin
      stored_tri = it.c;
      have_first = 1'b1;
      return;
    end
    if (!have_first) begin
      merge_expected_q.push_back(r);
      return;
    end
    have_first = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        s[i][k] = longint'($signed(stored_tri[i*3+k]));
        n[i][k] = longint'($signed(it.c[i*3+k]));
      end
    end
    u0 = first_unshared(s, n);
    u1 = first_unshared(n, s);
    if (u0 >= 0 && u1 >= 0) begin
      for (int i = 0; i < 3; i++) begin
        if (shared_v(s[i], n)) begin
          on = on_line(s[i], s[u0], n[u1]);
          if (!on && ext < 0) ext = i;
          if (on) inl = 1'b1;
        end
      end
      if (ext >= 0 && inl) begin
        r.merged = 1'b1;
        for (int k = 0; k < 3; k++) begin
          r.m[k] = CW'(s[u0][k]);
          r.m[3+k] = CW'(n[u1][k]);
          r.m[6+k] = CW'(s[ext][k]);
        end
      end
    end
    merge_expected_q.push_back(r);
  endfunction

  function automatic void push_tri(bit first, vert_t v0, vert_t v1, vert_t v2);
    tri_t t;
    t.first = first;
    for (int k = 0; k < 3; k++) begin
      t.c[k] = v0[k];
      t.c[3+k] = v1[k];
      t.c[6+k] = v2[k];
    end
    feed_q.push_back(t);
  endfunction

  function automatic vert_t rand_vert(int span);
    vert_t v;
    for (int k = 0; k < 3; k++) begin
      if (span == 0) v[k] = CW'($urandom);
      else v[k] = CW'($urandom_range(0, 2 * span) - span);
    end
    return v;
  endfunction

  function automatic vert_t jitter(vert_t v);
    vert_t r;
    int lim;
    lim = eps_now > 8 ? 8 : int'(eps_now);
    for (int k = 0; k < 3; k++) begin
      r[k] = v[k] + CW'(int'($urandom_range(0, 2 * lim)) - lim);
    end
    return r;
  endfunction

  // Shared edge B-C, C halfway between A and D, then shuffle vertex order.
  function automatic void push_pair();
    vert_t a;
    vert_t b;
    vert_t c;
    vert_t d;
    vert_t t;
    vert_t sv[3];
    vert_t nv[3];
    int span;
    int x;
    int y;
    span = $urandom_range(0, 1) ? 100000 : 400;
    a = rand_vert(span);
    t = rand_vert(span);
    b = rand_vert(span);
    for (int k = 0; k < 3; k++) begin
      c[k] = a[k] + t[k];
      d[k] = a[k] + 2 * t[k];
    end
    if ($urandom_range(0, 4) == 0) b = c + rand_vert(2);
    sv[0] = a; sv[1] = b; sv[2] = c;
    nv[0] = jitter(b); nv[1] = jitter(c); nv[2] = d;
    for (int r = 0; r < 2; r++) begin
      x = $urandom_range(0, 2); y = $urandom_range(0, 2);
      t = sv[x]; sv[x] = sv[y]; sv[y] = t;
      x = $urandom_range(0, 2); y = $urandom_range(0, 2);
      t = nv[x]; nv[x] = nv[y]; nv[y] = t;
    end
    push_tri(1'b1, sv[0], sv[1], sv[2]);
    push_tri(1'b0, nv[0], nv[1], nv[2]);
  endfunction

  function automatic void push_noise();
    case ($urandom_range(0, 3))
      0: push_tri(1'b0, rand_vert(0), rand_vert(0), rand_vert(0));
      1: push_tri(1'b1, rand_vert(0), rand_vert(0), rand_vert(0));
      2: begin
        push_tri(1'b1, rand_vert(300), rand_vert(300), rand_vert(300));
        push_tri(1'b0, rand_vert(300), rand_vert(300), rand_vert(300));
      end
      default: push_tri(1'b0, rand_vert(20), rand_vert(20), rand_vert(20));
    endcase
  endfunction

  task automatic wait_idle();
    while (feed_q.size() != 0 || in_valid || merge_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_eps(longint v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= tpmc_pkg::EPS_W'(v);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    eps_now = v;
  endtask

  initial begin
    vert_t lo;
    vert_t hi;
    vert_t z;
    vert_t p;
    vert_t q;
    longint eps_list[5];
    lo = {3{CW'(-524288)}};
    hi = {3{CW'(524287)}};
    z = '0;
    p = {CW'(100), CW'(0), CW'(0)};
    q = {CW'(0), CW'(100), CW'(0)};
    eps_list = '{1, 0, 65535, 16, 0};
    eps_list[4] = longint'($urandom_range(2, 65534));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_tri(1'b0, p, q, z);
    push_tri(1'b1, lo, hi, z);
    push_tri(1'b1, lo, hi, p);
    push_tri(1'b0, lo, hi, p);
    push_tri(1'b0, lo, hi, p);
    push_tri(1'b1, hi, lo, hi);
    push_tri(1'b0, lo, hi, lo);
    push_tri(1'b1, z, p, q);
    push_tri(1'b0, p, q, z);
    push_tri(1'b1, z, p, q);
    push_tri(1'b0, p, q, z + q);
    push_tri(1'b1, z, q, p);
    push_tri(1'b0, q, p + p, p);
    push_tri(1'b1, z, q, p);
    push_tri(1'b0, q, p, q + q);
    push_tri(1'b1, z, p, q);
    push_tri(1'b0, p, z, z);
    push_tri(1'b1, hi, z, lo);
    push_tri(1'b0, z, lo, q);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_eps(eps_list[ph]);
      end
      for (int n = 0; n < 120; n += 2) begin
        if ($urandom_range(0, 9) < 7) push_pair();
        else push_noise();
      end
    end
    wait_idle();
    if (fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_merge(item_q);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (feed_q.size() != 0) begin
          item_q <= feed_q.pop_front();
          in_valid <= 1'b1;
          send_gap = $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    merge_t act;
    merge_t exp_r;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      idle_cycles++;
      if ((in_valid && !in_stall) || cfg_we) idle_cycles = 0;
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        act.merged = merged;
        for (int k = 0; k < 9; k++) act.m[k] = mo[k];
        if (merge_expected_q.size() == 0) begin
          $display("%0t: unexpected transaction merged=%0b", $time, merged);
          fails++;
        end else begin
          exp_r = merge_expected_q.pop_front();
          if (exp_r.merged !== act.merged) begin
            $display("%0t: merged exp %0b act %0b", $time, exp_r.merged, act.merged);
            fails++;
          end
          for (int k = 0; k < 9; k++) begin
            if (exp_r.m[k] !== act.m[k]) begin
              $display("%0t: vertex field %0d exp %0d act %0d", $time, k,
                       $signed(exp_r.m[k]), $signed(act.m[k]));
              fails++;
            end
          end
        end
        recv_gap = $urandom_range(0, 3);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

endmodule

// ===== triangle_pair_merge_check.f =====
rtl/core/tpmc_pkg.sv
rtl/core/tpmc_mul.sv
rtl/core/tpmc_datapath.sv
rtl/core/tpmc_ctrl.sv
rtl/core/triangle_pair_merge_check.sv
bench/tb_top.sv
